// File: design/assert_macros.svh
// assertion macros for the coefficient unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post)
`define ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

// File: design/mca_pkg.sv
// ----------------------------------------------------------------------------
// mca_pkg
// types and constants shared by the coefficient unit modules
// ----------------------------------------------------------------------------
package mca_pkg;
  localparam int WORD_BITS = 32;
  localparam int MOD_BITS  = 31;

  typedef enum logic [2:0] {
    OP_NORM = 3'd0,
    OP_ADD  = 3'd1,
    OP_MUL  = 3'd2,
    OP_NEG  = 3'd3,
    OP_ZERO = 3'd4,
    OP_UNIT = 3'd5,
    OP_INV  = 3'd6,
    OP_NONE = 3'd7
  } op_t;

  localparam logic CFG_FIELD_MODE = 1'b0;
  localparam logic CFG_PRIME      = 1'b1;

  typedef struct packed {
    logic load;
    logic div_start;
    logic inv_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic need_div;
    logic need_inv;
    logic inv_done;
  } sts_t;
endpackage

// File: design/modular_coefficient_alu_core.sv
// ----------------------------------------------------------------------------
// modular_coefficient_alu_core
// coefficient unit over signed 32-bit integers or a prime field
// ----------------------------------------------------------------------------
// channel   dir  fields
// in        in   operation, operand_a, operand_b
// out       out  value, flag, overflow
// cfg       in   field_mode, prime_modulus
// integer mode: a request needs no division; field mode: reduction runs the
// 64-step restoring divider, and an inverse adds a division per euclid step
// registers reset to integer mode with modulus 0
// a stalled result holds the block; no request is taken until it leaves
module modular_coefficient_alu_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_operation,
  input  logic signed [31:0] in_operand_a,
  input  logic signed [31:0] in_operand_b,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_value,
  output logic               out_flag,
  output logic               out_overflow,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [30:0]        cfg_data
);
  logic        field_mode_r;
  logic [30:0] prime_modulus_r;
  mca_pkg::cmd_t cmd;
  mca_pkg::sts_t sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_mode_r    <= 1'b0;
      prime_modulus_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == mca_pkg::CFG_FIELD_MODE) field_mode_r <= cfg_data[0];
      else                                       prime_modulus_r <= cfg_data;
    end
  end

  mca_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .cmd, .sts
  );

  mca_datapath u_dp (
    .clk,
    .field_mode   (field_mode_r),
    .prime_modulus(prime_modulus_r),
    .in_operation,
    .in_operand_a,
    .in_operand_b,
    .cmd,
    .sts,
    .out_value,
    .out_flag,
    .out_overflow
  );
endmodule

// File: design/mca_ctrl.sv
// ----------------------------------------------------------------------------
// mca_ctrl
// sequencer for load, reduction, inverse steps and result hand-off
// ----------------------------------------------------------------------------
module mca_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output mca_pkg::cmd_t cmd,
  input  mca_pkg::sts_t sts
);
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIVS = 5'b00010,
    S_DIVW = 5'b00100,
    S_INV  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DIVS;
        end
      end
      S_DIVS: begin
        if (sts.need_div) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIVW;
        end else if (sts.need_inv) begin
          state_nxt = S_INV;
        end else begin
          cmd.finish = 1'b1;
          state_nxt  = S_OUT;
        end
      end
      S_DIVW: begin
        if (sts.div_done) begin
          if (sts.need_inv) begin
            state_nxt = S_INV;
          end else begin
            cmd.finish = 1'b1;
            state_nxt  = S_OUT;
          end
        end
      end
      S_INV: begin
        if (sts.inv_done) begin
          cmd.finish = 1'b1;
          state_nxt  = S_OUT;
        end else begin
          cmd.inv_step = 1'b1;
          state_nxt    = S_DIVW;
        end
      end
      S_OUT: begin
        if (!out_stall) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  `include "assert_macros.svh"
  `ASSERT_NEXT(a_load_leaves_idle, clk, rst_n, cmd.load, state_r == S_DIVS)
  `ASSERT_IMPLIES(a_out_only_in_out, clk, rst_n, out_valid, in_stall)
  `ASSERT_NEXT(a_finish_shows, clk, rst_n, cmd.finish, out_valid)
endmodule

// File: design/mca_datapath.sv
// ----------------------------------------------------------------------------
// mca_datapath
// operand preparation, shared restoring divider and euclid registers
// ----------------------------------------------------------------------------
module mca_datapath (
  input  logic                         clk,
  input  logic                         field_mode,
  input  logic [mca_pkg::MOD_BITS-1:0] prime_modulus,
  input  logic [2:0]                   in_operation,
  input  logic signed [31:0]           in_operand_a,
  input  logic signed [31:0]           in_operand_b,
  input  mca_pkg::cmd_t                cmd,
  output mca_pkg::sts_t                sts,
  output logic signed [31:0]           out_value,
  output logic                         out_flag,
  output logic                         out_overflow
);
  typedef mca_pkg::op_t op_t;

  // divider: 64-bit magnitude over 31-bit divisor, one bit a cycle
  logic [2:0]         op_r;
  logic               fm_r;
  logic signed [65:0] x_r, x_nxt;
  logic [63:0]        dq_r;     // dividend shifting into quotient
  logic [31:0]        drem_r;
  logic [30:0]        dvs_r;
  logic [6:0]         dcnt_r;
  logic               dneg_r;
  logic               dbusy_r;
  logic               inv_r;
  logic [30:0]        oldr_r, rr_r;
  logic signed [32:0] olds_r, ss_r;
  logic signed [31:0] val_r, val_nxt;
  logic               flag_r, ovf_r;
  logic               flag_nxt, ovf_nxt;

  logic signed [32:0] a_e, b_e;
  logic [65:0]        xabs;
  logic [31:0]        trial;
  logic               sub_ok;
  logic [30:0]        res_mod;
  logic               p_small;
  logic [30:0]        q31;
  logic [62:0]        qs_prod;
  logic signed [32:0] s_new;

  assign a_e = 33'(in_operand_a);
  assign b_e = 33'(in_operand_b);
  assign p_small = (prime_modulus < 31'd2);

  always_comb begin
    case (op_t'(in_operation))
      mca_pkg::OP_ADD: x_nxt = 66'(a_e + b_e);
      mca_pkg::OP_MUL: x_nxt = 66'(a_e * b_e);
      mca_pkg::OP_NEG: x_nxt = -66'(a_e);
      default:         x_nxt = 66'(a_e);
    endcase
  end

  assign xabs   = x_r[65] ? 66'(-x_r) : 66'(x_r);
  assign trial  = {drem_r[30:0], dq_r[63]};
  assign sub_ok = (trial >= {1'b0, dvs_r});
  // residue in 0..p-1 from sign and remainder
  assign res_mod = (dneg_r && drem_r[30:0] != 31'd0) ? 31'(dvs_r - drem_r[30:0])
                                                     : drem_r[30:0];
  assign q31     = dq_r[30:0];
  assign qs_prod = 63'($signed({1'b0, q31}) * ss_r);
  assign s_new   = 33'(olds_r - $signed(qs_prod[32:0]));

  wire ovf_int = (x_r > 66'sd2147483647) || (x_r < -66'sd2147483648);

  assign sts.need_div = fm_r && !p_small && (op_r != mca_pkg::OP_NONE) && !inv_r;
  assign sts.need_inv = fm_r && !p_small && (op_r == mca_pkg::OP_INV) && !inv_r ?
                        (res_mod != 31'd0) : inv_r;
  assign sts.div_done = !dbusy_r;
  assign sts.inv_done = inv_r && (rr_r == 31'd0);

  always_comb begin
    val_nxt  = '0;
    flag_nxt = 1'b0;
    ovf_nxt  = 1'b0;
    if (!fm_r) begin
      if (ovf_int && op_r != mca_pkg::OP_NONE) begin
        ovf_nxt = 1'b1;
      end else begin
        case (op_t'(op_r))
          mca_pkg::OP_ZERO: flag_nxt = (x_r == 66'sd0);
          mca_pkg::OP_UNIT: flag_nxt = (x_r == 66'sd1) || (x_r == -66'sd1);
          mca_pkg::OP_INV: begin
            if ((x_r == 66'sd1) || (x_r == -66'sd1)) begin
              flag_nxt = 1'b1;
              val_nxt  = 32'(x_r);
            end
          end
          mca_pkg::OP_NONE: val_nxt = '0;
          default: val_nxt = 32'(x_r);
        endcase
      end
    end else if (p_small) begin
      flag_nxt = (op_r == mca_pkg::OP_ZERO);
    end else if (inv_r) begin
      // old_r here is the last nonzero remainder
      if (rr_r == 31'd0 && oldr_r == 31'd1) begin
        flag_nxt = 1'b1;
        val_nxt  = olds_r[32] ? 32'(olds_r + $signed({2'b0, prime_modulus}))
                              : 32'(olds_r);
      end
    end else begin
      case (op_t'(op_r))
        mca_pkg::OP_ZERO: flag_nxt = (res_mod == 31'd0);
        mca_pkg::OP_UNIT: flag_nxt = (res_mod != 31'd0);
        mca_pkg::OP_INV:  flag_nxt = 1'b0;
        mca_pkg::OP_NONE: val_nxt  = '0;
        default:          val_nxt  = 32'({1'b0, res_mod});
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_operation;
      fm_r    <= field_mode;
      x_r     <= x_nxt;
      inv_r   <= 1'b0;
      dbusy_r <= 1'b0;
      drem_r  <= '0;
      dneg_r  <= 1'b0;
    end else if (cmd.div_start) begin
      dq_r    <= xabs[63:0];
      drem_r  <= '0;
      dvs_r   <= prime_modulus;
      dneg_r  <= x_r[65];
      dcnt_r  <= 7'd64;
      dbusy_r <= 1'b1;
    end else if (cmd.inv_step) begin
      if (!inv_r) begin
        // first step: old_r = p, r = a mod p
        inv_r  <= 1'b1;
        oldr_r <= dvs_r;
        rr_r   <= res_mod;
        olds_r <= 33'sd0;
        ss_r   <= 33'sd1;
        dq_r   <= {dvs_r, 33'd0};
        dvs_r  <= res_mod;
      end else begin
        oldr_r <= rr_r;
        rr_r   <= drem_r[30:0];
        olds_r <= ss_r;
        ss_r   <= s_new;
        dq_r   <= {rr_r, 33'd0};
        dvs_r  <= drem_r[30:0];
      end
      drem_r  <= '0;
      dneg_r  <= 1'b0;
      dcnt_r  <= 7'd31;
      dbusy_r <= 1'b1;
    end else if (dbusy_r) begin
      dq_r   <= {dq_r[62:0], sub_ok};
      drem_r <= sub_ok ? 32'(trial - {1'b0, dvs_r}) : trial;
      dcnt_r <= dcnt_r - 7'd1;
      if (dcnt_r == 7'd1) dbusy_r <= 1'b0;
    end
    if (cmd.finish) begin
      val_r  <= val_nxt;
      flag_r <= flag_nxt;
      ovf_r  <= ovf_nxt;
    end
  end

  assign out_value    = val_r;
  assign out_flag     = flag_r;
  assign out_overflow = ovf_r;
endmodule
